// File: hw/rtl/ktaf_pkg.sv
// Shared types and constants for the tilt-angle Kalman filter.
package ktaf_pkg;

    localparam int DEF_WORD_BITS = 48;
    localparam int DEF_FRAC_BITS = 24;
    localparam int CFG_BITS      = 47;
    localparam int CFG_IDX_BITS  = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ANGLE_NOISE   = 2'd0,
        CFG_BIAS_NOISE    = 2'd1,
        CFG_MEASURE_NOISE = 2'd2,
        CFG_TIME_STEP     = 2'd3
    } cfg_index_t;

    localparam logic [CFG_BITS-1:0] RST_ANGLE_NOISE   = 47'd1678;
    localparam logic [CFG_BITS-1:0] RST_BIAS_NOISE    = 47'd503;
    localparam logic [CFG_BITS-1:0] RST_MEASURE_NOISE = 47'd503316;
    localparam logic [CFG_BITS-1:0] RST_TIME_STEP     = 47'd83886;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

// File: hw/rtl/ktaf_sample_if.sv
// Input channel: one gyro rate / accelerometer angle word.
interface ktaf_sample_if #(
    parameter int WORD_BITS = ktaf_pkg::DEF_WORD_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] gyro_rate;
    logic signed [WORD_BITS-1:0] accel_angle;

    modport source (output valid, output gyro_rate, output accel_angle, input ready);
    modport sink   (input valid, input gyro_rate, input accel_angle, output ready);
endinterface

// File: hw/rtl/ktaf_result_if.sv
// Output channel: filtered angle and bias-corrected rate word.
interface ktaf_result_if #(
    parameter int WORD_BITS = ktaf_pkg::DEF_WORD_BITS
) ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] filtered_angle;
    logic signed [WORD_BITS-1:0] corrected_rate;

    modport source (output valid, output filtered_angle, output corrected_rate, input ready);
    modport sink   (input valid, input filtered_angle, input corrected_rate, output ready);
endinterface

// File: hw/rtl/ktaf_arith.sv
// Shared fixed-point multiply (16-bit digit per cycle) and restoring divide unit.
module ktaf_arith #(
    parameter int WORD_BITS = ktaf_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ktaf_pkg::DEF_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ktaf_pkg::arith_req_t   req,
    input  logic [WORD_BITS-1:0]   a,
    input  logic [WORD_BITS-1:0]   b,
    output logic                   done,
    output logic [WORD_BITS-1:0]   result
);
    import ktaf_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int NDIG = (W + 15) / 16;
    localparam int DW   = 16 * NDIG;
    localparam int AW   = W + DW + F;
    localparam int QW   = W + F;
    localparam int CW   = $clog2(QW + 1);

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} unit_state_t;

    unit_state_t     st_reg, st_next;
    logic            done_reg, done_next;
    logic [W-1:0]    res_reg, res_next;
    arith_op_t       op_reg, op_next;
    logic            neg_reg, neg_next;
    logic [W-1:0]    ua_reg, ua_next;
    logic [DW-1:0]   ub_reg, ub_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [QW-1:0]   nq_reg, nq_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic [W-1:0]    mag_a, mag_b;
    logic [15:0]     digit;
    logic [W+15:0]   prod;
    logic [W:0]      r_sh, r_diff;
    logic            div_ge;
    logic            over;
    logic [W-2:0]    mag_q;
    logic [W-1:0]    fin_res;

    assign mag_a = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;

    always_comb
    begin
        digit  = ub_reg[DW-1 -: 16];
        prod   = ua_reg * digit;
        r_sh   = {rem_reg, nq_reg[QW-1]};
        div_ge = r_sh >= {1'b0, ub_reg[W-1:0]};
        r_diff = r_sh - {1'b0, ub_reg[W-1:0]};
        if (op_reg == OP_MUL)
        begin
            over  = |acc_reg[AW-1:W+F-1];
            mag_q = acc_reg[W+F-2:F];
        end
        else
        begin
            over  = |nq_reg[QW-1:W-1];
            mag_q = nq_reg[W-2:0];
        end
        if (over)
            fin_res = neg_reg ? WMIN : WMAX;
        else if (neg_reg)
            fin_res = ~{1'b0, mag_q} + 1'b1;
        else
            fin_res = {1'b0, mag_q};
    end

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        ua_next   = ua_reg;
        ub_next   = ub_reg;
        acc_next  = acc_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        unique case (st_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    neg_next = a[W-1] ^ b[W-1];
                    ua_next  = mag_a;
                    ub_next  = DW'(mag_b);
                    acc_next = '0;
                    nq_next  = {mag_a, {F{1'b0}}};
                    rem_next = '0;
                    cnt_next = '0;
                    if (req.op == OP_DIV && mag_a == '0)
                    begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                    else if (req.op == OP_DIV && mag_b == '0)
                    begin
                        // zero divisor: saturate toward the numerator's sign
                        res_next  = a[W-1] ? WMIN : WMAX;
                        done_next = 1'b1;
                    end
                    else
                        st_next = (req.op == OP_MUL) ? U_MUL : U_DIV;
                end
            end
            U_MUL:
            begin
                acc_next = (acc_reg << 16) + AW'(prod);
                ub_next  = ub_reg << 16;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NDIG - 1))
                    st_next = U_FIN;
            end
            U_DIV:
            begin
                rem_next = div_ge ? r_diff[W-1:0] : r_sh[W-1:0];
                nq_next  = {nq_reg[QW-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                    st_next = U_FIN;
            end
            U_FIN:
            begin
                res_next  = fin_res;
                done_next = 1'b1;
                st_next   = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            res_reg  <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        acc_reg <= acc_next;
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: hw/rtl/kalman_tilt_angle_filter.sv
// One word at a time: a new sample is accepted only in the idle state, after the previous word has
//   left the output step; a gain with zero numerator or divisor finishes early.
// Shared multiply/divide unit: 16 multiplier bits per cycle, one quotient bit per cycle.
// Result waits in an output register while the next word runs; a result still stalled
//   holds the next one at its output step.
// Reset: estimates and off-diagonal covariance to zero, diagonal to 1.0, noise registers to defaults.
module kalman_tilt_angle_filter #(
    parameter int WORD_BITS = ktaf_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ktaf_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ktaf_sample_if.sink                       sample,
    ktaf_result_if.source                     result,
    input  logic                              cfg_write,
    input  logic [ktaf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ktaf_pkg::CFG_BITS-1:0]     cfg_data
);
    import ktaf_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int XW = (CFG_BITS > W) ? CFG_BITS : W;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE  = (FRAC_BITS >= W - 1) ? WMAX :
                                    (W'(1) << FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_ANG, S_ERR, S_PAA, S_POFF, S_PBB, S_INN, S_GA, S_GB,
        S_UBB, S_UAB, S_UBA, S_UAA, S_UANG, S_UBIAS, S_OUT
    } seq_state_t;

    function automatic logic [W-1:0] sadd(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        if (s[W] != s[W-1])
            sadd = s[W] ? WMIN : WMAX;
        else
            sadd = s[W-1:0];
    endfunction

    function automatic logic [W-1:0] ssub(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W:0] s;
        s = {x[W-1], x} - {y[W-1], y};
        if (s[W] != s[W-1])
            ssub = s[W] ? WMIN : WMAX;
        else
            ssub = s[W-1:0];
    endfunction

    // unsigned register value clipped to the largest positive word
    function automatic logic [W-1:0] cfg_word(input logic [CFG_BITS-1:0] v);
        logic [XW-1:0] ext;
        ext = XW'(v);
        if (ext > XW'(WMAX))
            cfg_word = WMAX;
        else
            cfg_word = ext[W-1:0];
    endfunction

    logic [CFG_BITS-1:0] qa_reg, qg_reg, rm_reg, dt_reg;

    seq_state_t   state_reg, state_next;
    logic         issued_reg, issued_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] angle_reg, angle_next;
    logic [W-1:0] bias_reg, bias_next;
    logic [W-1:0] caa_reg, caa_next;
    logic [W-1:0] cab_reg, cab_next;
    logic [W-1:0] cba_reg, cba_next;
    logic [W-1:0] cbb_reg, cbb_next;

    logic [W-1:0] gyro_reg, gyro_next;
    logic [W-1:0] accel_reg, accel_next;
    logic [W-1:0] err_reg, err_next;
    logic [W-1:0] daa_reg, daa_next;
    logic [W-1:0] innov_reg, innov_next;
    logic [W-1:0] gain_a_reg, gain_a_next;
    logic [W-1:0] gain_b_reg, gain_b_next;
    logic [W-1:0] out_angle_reg, out_angle_next;
    logic [W-1:0] out_rate_reg, out_rate_next;

    logic [W-1:0] dt, qa, qg, rm;
    arith_req_t   a_req;
    logic [W-1:0] op_a, op_b;
    logic         a_done;
    logic [W-1:0] a_res;
    logic         arith_state;
    seq_state_t   after;

    assign dt = cfg_word(dt_reg);
    assign qa = cfg_word(qa_reg);
    assign qg = cfg_word(qg_reg);
    assign rm = cfg_word(rm_reg);

    ktaf_arith #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (a_req),
        .a      (op_a),
        .b      (op_b),
        .done   (a_done),
        .result (a_res)
    );

    // operand select and follow-on state for each unit operation
    always_comb
    begin
        op_a        = gain_a_reg;
        op_b        = err_reg;
        a_req.op    = OP_MUL;
        arith_state = 1'b1;
        after       = S_IDLE;
        unique case (state_reg)
            S_ANG:   begin op_a = ssub(gyro_reg, bias_reg); op_b = dt; after = S_ERR; end
            S_PAA:   begin op_a = ssub(daa_reg, cba_reg);   op_b = dt; after = S_POFF; end
            S_POFF:  begin op_a = ssub('0, cbb_reg);        op_b = dt; after = S_PBB; end
            S_PBB:   begin op_a = qg;                       op_b = dt; after = S_INN; end
            S_GA:
            begin
                op_a = caa_reg; op_b = innov_reg; a_req.op = OP_DIV; after = S_GB;
            end
            S_GB:
            begin
                op_a = cba_reg; op_b = innov_reg; a_req.op = OP_DIV; after = S_UBB;
            end
            S_UBB:   begin op_a = gain_b_reg; op_b = cab_reg; after = S_UAB; end
            S_UAB:   begin op_a = gain_a_reg; op_b = cab_reg; after = S_UBA; end
            S_UBA:   begin op_a = gain_b_reg; op_b = caa_reg; after = S_UAA; end
            S_UAA:   begin op_a = gain_a_reg; op_b = caa_reg; after = S_UANG; end
            S_UANG:  begin op_a = gain_a_reg; op_b = err_reg; after = S_UBIAS; end
            S_UBIAS: begin op_a = gain_b_reg; op_b = err_reg; after = S_OUT; end
            S_IDLE, S_ERR, S_INN, S_OUT: arith_state = 1'b0;
        endcase
        a_req.start = arith_state && !issued_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg && !result.ready;
        angle_next     = angle_reg;
        bias_next      = bias_reg;
        caa_next       = caa_reg;
        cab_next       = cab_reg;
        cba_next       = cba_reg;
        cbb_next       = cbb_reg;
        gyro_next      = gyro_reg;
        accel_next     = accel_reg;
        err_next       = err_reg;
        daa_next       = daa_reg;
        innov_next     = innov_reg;
        gain_a_next    = gain_a_reg;
        gain_b_next    = gain_b_reg;
        out_angle_next = out_angle_reg;
        out_rate_next  = out_rate_reg;

        if (arith_state)
        begin
            if (!issued_reg)
                issued_next = 1'b1;
            else if (a_done)
            begin
                issued_next = 1'b0;
                state_next  = after;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    gyro_next  = sample.gyro_rate;
                    accel_next = sample.accel_angle;
                    state_next = S_ANG;
                end
            end
            S_ANG:
                if (a_done) angle_next = sadd(angle_reg, a_res);
            S_ERR:
            begin
                err_next   = ssub(accel_reg, angle_reg);
                daa_next   = ssub(qa, cab_reg);
                state_next = S_PAA;
            end
            S_PAA:
                if (a_done) caa_next = sadd(caa_reg, a_res);
            S_POFF:
            begin
                if (a_done)
                begin
                    cab_next = sadd(cab_reg, a_res);
                    cba_next = sadd(cba_reg, a_res);
                end
            end
            S_PBB:
                if (a_done) cbb_next = sadd(cbb_reg, a_res);
            S_INN:
            begin
                innov_next = sadd(rm, caa_reg);
                state_next = S_GA;
            end
            S_GA:
                if (a_done) gain_a_next = a_res;
            S_GB:
                if (a_done) gain_b_next = a_res;
            S_UBB:
                if (a_done) cbb_next = ssub(cbb_reg, a_res);
            S_UAB:
                if (a_done) cab_next = ssub(cab_reg, a_res);
            S_UBA:
                if (a_done) cba_next = ssub(cba_reg, a_res);
            S_UAA:
                if (a_done) caa_next = ssub(caa_reg, a_res);
            S_UANG:
                if (a_done) angle_next = sadd(angle_reg, a_res);
            S_UBIAS:
                if (a_done) bias_next = sadd(bias_reg, a_res);
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_angle_next = angle_reg;
                    out_rate_next  = ssub(gyro_reg, bias_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            caa_reg       <= ONE;
            cab_reg       <= '0;
            cba_reg       <= '0;
            cbb_reg       <= ONE;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            caa_reg       <= caa_next;
            cab_reg       <= cab_next;
            cba_reg       <= cba_next;
            cbb_reg       <= cbb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= RST_ANGLE_NOISE;
            qg_reg <= RST_BIAS_NOISE;
            rm_reg <= RST_MEASURE_NOISE;
            dt_reg <= RST_TIME_STEP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ANGLE_NOISE:   qa_reg <= cfg_data;
                CFG_BIAS_NOISE:    qg_reg <= cfg_data;
                CFG_MEASURE_NOISE: rm_reg <= cfg_data;
                CFG_TIME_STEP:     dt_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        gyro_reg      <= gyro_next;
        accel_reg     <= accel_next;
        err_reg       <= err_next;
        daa_reg       <= daa_next;
        innov_reg     <= innov_next;
        gain_a_reg    <= gain_a_next;
        gain_b_reg    <= gain_b_next;
        out_angle_reg <= out_angle_next;
        out_rate_reg  <= out_rate_next;
    end

    assign sample.ready          = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.filtered_angle = out_angle_reg;
    assign result.corrected_rate = out_rate_reg;

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> state_reg == S_ANG && !sample.ready)
        else $error("accepted word did not start the filter sequence");

    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        a_done |-> issued_reg && arith_state)
        else $error("arithmetic unit finished with no operation pending");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == S_OUT))
        else $error("result word raised outside the output step");

endmodule

// File: bench/ktaf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the tilt-angle Kalman filter: tracks config, predicts every output word, compares.
module ktaf_checker #(
    parameter int WORD_BITS = ktaf_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ktaf_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ktaf_sample_if                            sample,
    ktaf_result_if                            result,
    input  logic                              cfg_write,
    input  logic [ktaf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ktaf_pkg::CFG_BITS-1:0]     cfg_data,
    output int unsigned                       pending,
    output int unsigned                       mismatches,
    output logic signed [WORD_BITS-1:0]       cov_aa_ahead
);
    import ktaf_pkg::*;

    localparam longint W_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;
    localparam longint FX_ONE = longint'(1) <<< FRAC_BITS;
    localparam logic [127:0] MAG_LIMIT = 128'(1) << (WORD_BITS - 1);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] angle;
        logic signed [WORD_BITS-1:0] rate;
    } tilt_out_t;

    logic [CFG_BITS-1:0] q_angle_reg, q_bias_reg, r_meas_reg, dt_reg;
    longint est_angle, est_bias, p00, p01, p10, p11;
    tilt_out_t predicted_outputs[$];
    tilt_out_t want;
    int unsigned words_checked;
    longint ahead;

    function automatic longint clamp(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return clamp(a - b);
    endfunction

    function automatic longint reg_word(logic [CFG_BITS-1:0] v);
        longint w;
        w = longint'(v);
        return (w > W_MAX) ? W_MAX : w;
    endfunction

    function automatic logic [127:0] magnitude(longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    // Signed result from a wide magnitude, saturated to the word
    function automatic longint sign_sat(logic [127:0] m, bit neg);
        if (neg) return (m >= MAG_LIMIT) ? W_MIN : -longint'(m[63:0]);
        return (m >= MAG_LIMIT) ? W_MAX : longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return sign_sat((magnitude(a) * magnitude(b)) >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    // Zero divisor: zero numerator gives zero, else the extreme of the numerator's sign
    function automatic longint fx_div(longint a, longint b);
        if (a == 0) return 0;
        if (b == 0) return (a < 0) ? W_MIN : W_MAX;
        return sign_sat((magnitude(a) << FRAC_BITS) / magnitude(b), (a < 0) != (b < 0));
    endfunction

    function automatic tilt_out_t advance_filter(longint gyro, longint accel);
        longint dt, err, d_aa, d_off, gain_a, gain_b, pa, pb, pab, innov, rate_fx;
        tilt_out_t o;
        dt = reg_word(dt_reg);
        est_angle = add_sat(est_angle, fx_mul(sub_sat(gyro, est_bias), dt));
        err = sub_sat(accel, est_angle);

        d_aa = sub_sat(sub_sat(reg_word(q_angle_reg), p01), p10);
        d_off = sub_sat(0, p11);
        p00 = add_sat(p00, fx_mul(d_aa, dt));
        p01 = add_sat(p01, fx_mul(d_off, dt));
        p10 = add_sat(p10, fx_mul(d_off, dt));
        p11 = add_sat(p11, fx_mul(reg_word(q_bias_reg), dt));

        pa = p00;
        pb = p10;
        pab = p01;
        innov = add_sat(reg_word(r_meas_reg), pa);
        gain_a = fx_div(pa, innov);
        gain_b = fx_div(pb, innov);

        p00 = sub_sat(p00, fx_mul(gain_a, pa));
        p01 = sub_sat(p01, fx_mul(gain_a, pab));
        p10 = sub_sat(p10, fx_mul(gain_b, pa));
        p11 = sub_sat(p11, fx_mul(gain_b, pab));

        est_angle = add_sat(est_angle, fx_mul(gain_a, err));
        est_bias = add_sat(est_bias, fx_mul(gain_b, err));

        rate_fx = sub_sat(gyro, est_bias);
        o.angle = est_angle[WORD_BITS-1:0];
        o.rate = rate_fx[WORD_BITS-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] word %0d: %s", $time, words_checked, msg);
        mismatches++;
    endtask

    // P00 after the predict half of the next word, under the current config
    always_comb
    begin
        ahead = add_sat(p00, fx_mul(sub_sat(sub_sat(reg_word(q_angle_reg), p01), p10),
                                    reg_word(dt_reg)));
        cov_aa_ahead = ahead[WORD_BITS-1:0];
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_angle_reg = RST_ANGLE_NOISE;
            q_bias_reg = RST_BIAS_NOISE;
            r_meas_reg = RST_MEASURE_NOISE;
            dt_reg = RST_TIME_STEP;
            est_angle = 0;
            est_bias = 0;
            p00 = FX_ONE;
            p01 = 0;
            p10 = 0;
            p11 = FX_ONE;
            predicted_outputs.delete();
            words_checked = 0;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ANGLE_NOISE:   q_angle_reg = cfg_data;
                    CFG_BIAS_NOISE:    q_bias_reg = cfg_data;
                    CFG_MEASURE_NOISE: r_meas_reg = cfg_data;
                    CFG_TIME_STEP:     dt_reg = cfg_data;
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (predicted_outputs.size() == 0)
                    report_mismatch($sformatf("unexpected word angle=%0d rate=%0d",
                                              result.filtered_angle, result.corrected_rate));
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (result.filtered_angle !== want.angle)
                        report_mismatch($sformatf("filtered_angle got %0d expected %0d",
                                                  result.filtered_angle, want.angle));
                    if (result.corrected_rate !== want.rate)
                        report_mismatch($sformatf("corrected_rate got %0d expected %0d",
                                                  result.corrected_rate, want.rate));
                end
                words_checked++;
            end

            if (sample.valid && sample.ready)
                predicted_outputs.push_back(advance_filter(longint'(sample.gyro_rate),
                                                           longint'(sample.accel_angle)));

            pending <= predicted_outputs.size();
        end
    end

endmodule

// File: bench/tb_kalman_tilt_angle_filter.sv
`timescale 1ns / 1ps
// Top-level testbench for the tilt-angle Kalman filter: clock, reset, stimulus and verdict.
module tb_kalman_tilt_angle_filter;
    import ktaf_pkg::*;

    localparam int WB = DEF_WORD_BITS;
    localparam int FB = DEF_FRAC_BITS;
    localparam int unsigned CYCLE_LIMIT = 2_500_000;
    localparam int unsigned ITEM_TARGET = 2000;
    localparam int unsigned QUIET_FROM = 1800;

    localparam logic signed [WB-1:0] WORD_MAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic signed [WB-1:0] WORD_MIN = {1'b1, {(WB-1){1'b0}}};
    localparam logic signed [WB-1:0] WORD_ONE = WB'(1) <<< FB;
    localparam logic [CFG_BITS-1:0] CFG_FULL = '1;
    localparam logic [CFG_BITS-1:0] CFG_ONE = CFG_BITS'(1) << FB;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    int unsigned pending;
    int unsigned mismatches;
    logic signed [WB-1:0] cov_aa_ahead;

    int unsigned words_sent;
    int unsigned cycle_count;
    bit gaps_on;
    int unsigned stall_odds;

    ktaf_sample_if #(.WORD_BITS(WB)) sample_ch ();
    ktaf_result_if #(.WORD_BITS(WB)) result_ch ();

    kalman_tilt_angle_filter #(
        .WORD_BITS(WB),
        .FRAC_BITS(FB)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ktaf_checker #(
        .WORD_BITS(WB),
        .FRAC_BITS(FB)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending(pending),
        .mismatches(mismatches),
        .cov_aa_ahead(cov_aa_ahead)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Output back-pressure: random stalls on the result ready
    initial
    begin
        int unsigned hold;
        hold = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    result_ch.ready <= 1'b1;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                result_ch.ready <= 1'b0;
                hold = $urandom_range(1, 19);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic logic [WB-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[WB-1:0];
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_reg();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[CFG_BITS-1:0];
    endfunction

    function automatic logic signed [WB-1:0] edge_word();
        case ($urandom_range(0, 5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return '1;
            4: return WB'(1);
            default: return WORD_ONE;
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] edge_reg(bit nonzero);
        logic [CFG_BITS-1:0] v;
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = CFG_FULL;
            2: v = CFG_ONE;
            default: v = rand_reg();
        endcase
        if (nonzero && v == 0)
            v = CFG_BITS'(1);
        return v;
    endfunction

    // Mostly plausible motion, some raw bit patterns, some extremes
    function automatic void next_sample(output logic signed [WB-1:0] g,
                                        output logic signed [WB-1:0] a);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
        begin
            g = $signed(rand_word()) >>> 17;
            a = $signed(rand_word()) >>> 21;
        end
        else if (pick < 17)
        begin
            g = rand_word();
            a = rand_word();
        end
        else
        begin
            g = edge_word();
            a = $urandom_range(0, 1) ? edge_word() : $signed(rand_word()) >>> 21;
        end
    endfunction

    task automatic send_word(input logic signed [WB-1:0] g, input logic signed [WB-1:0] a);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.gyro_rate <= g;
        sample_ch.accel_angle <= a;
        do @(posedge clk); while (!sample_ch.ready);
        words_sent++;
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_BITS-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic program_filter(input logic [CFG_BITS-1:0] qa, input logic [CFG_BITS-1:0] qg,
                                  input logic [CFG_BITS-1:0] rm, input logic [CFG_BITS-1:0] dt);
        wait_idle();
        write_reg(CFG_ANGLE_NOISE, qa);
        write_reg(CFG_BIAS_NOISE, qg);
        write_reg(CFG_MEASURE_NOISE, rm);
        write_reg(CFG_TIME_STEP, dt);
        cfg_write <= 1'b0;
    endtask

    // Look for a config under which the next word sees measure_noise + P00 == 0
    task automatic try_zero_innovation(output bit hit);
        logic signed [WB-1:0] ahead;
        logic [CFG_BITS-1:0] rm;
        hit = 1'b0;
        wait_idle();
        for (int c = 0; c < 4 && !hit; c++)
        begin
            write_reg(CFG_ANGLE_NOISE, c[0] ? CFG_FULL : '0);
            write_reg(CFG_TIME_STEP, c[1] ? CFG_ONE : CFG_FULL);
            cfg_write <= 1'b0;
            @(posedge clk);
            ahead = cov_aa_ahead;
            if (ahead < 0 && ahead != WORD_MIN)
            begin
                hit = 1'b1;
                rm = CFG_BITS'(-ahead);
                write_reg(CFG_MEASURE_NOISE, rm);
                cfg_write <= 1'b0;
            end
        end
    endtask

    initial
    begin
        logic signed [WB-1:0] g, a;
        logic [CFG_BITS-1:0] rm;
        int unsigned kind, count;
        bit hit, quiet;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_ANGLE_NOISE;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.gyro_rate = '0;
        sample_ch.accel_angle = '0;
        gaps_on = 1'b1;
        stall_odds = 3;
        words_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under reset config
        send_word('0, '0);
        send_word(WORD_ONE, WORD_ONE);
        send_word(WORD_MAX, WORD_MAX);
        send_word(WORD_MIN, WORD_MIN);
        send_word(WORD_MAX, WORD_MIN);
        send_word(WORD_MIN, WORD_MAX);
        send_word('1, WB'(1));

        program_filter(CFG_FULL, CFG_FULL, CFG_FULL, CFG_FULL);
        send_word(WORD_ONE, -WORD_ONE);
        send_word(WORD_MIN, WORD_MAX);

        // zero step: nothing advances in the predict half
        program_filter('0, '0, CFG_BITS'(1), '0);
        send_word(WORD_MAX, '0);
        send_word(-WORD_ONE, WORD_MIN);

        // huge step drives the covariance into saturation and negative divisors
        program_filter('0, '0, CFG_BITS'(1), CFG_FULL);
        send_word(WORD_ONE, WORD_ONE);
        send_word('0, WORD_MAX);
        send_word(WORD_MIN, '0);
        for (int k = 0; k < 4; k++)
        begin
            try_zero_innovation(hit);
            send_word(edge_word(), edge_word());
        end

        // Random phases
        while (words_sent < ITEM_TARGET)
        begin
            quiet = words_sent >= QUIET_FROM;
            kind = $urandom_range(0, 3);
            if (kind == 0)
                program_filter(RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEASURE_NOISE, RST_TIME_STEP);
            else if (kind == 1)
                program_filter(CFG_BITS'($urandom_range(0, 20000)),
                               CFG_BITS'($urandom_range(0, 5000)),
                               CFG_BITS'($urandom_range(1, 1 << 25)),
                               CFG_BITS'($urandom_range(1, 1 << 23)));
            else if (kind == 2)
            begin
                rm = rand_reg();
                if (rm == 0)
                    rm = CFG_BITS'(1);
                program_filter(rand_reg(), rand_reg(), rm, rand_reg());
            end
            else
            begin
                program_filter(edge_reg(1'b0), edge_reg(1'b0), edge_reg(1'b1), edge_reg(1'b0));
                if ($urandom_range(0, 1))
                    try_zero_innovation(hit);
            end

            gaps_on = !quiet && $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 3))
                0: stall_odds = 0;
                1: stall_odds = 2;
                2: stall_odds = 4;
                default: stall_odds = 8;
            endcase
            if (quiet)
                stall_odds = 0;

            count = $urandom_range(40, 160);
            for (int k = 0; k < count && words_sent < ITEM_TARGET; k++)
            begin
                next_sample(g, a);
                send_word(g, a);
            end
        end

        wait_idle();
        repeat (250) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ktaf_pkg.sv
hw/rtl/ktaf_sample_if.sv
hw/rtl/ktaf_result_if.sv
hw/rtl/ktaf_arith.sv
hw/rtl/kalman_tilt_angle_filter.sv
bench/ktaf_checker.sv
bench/tb_kalman_tilt_angle_filter.sv
